FILE: src/nsos_pkg.sv
// Shared types and constants for the nearest seed owner selector.
// No dependencies; imported by nsos_raster, nearest_seed_owner_select and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package nsos_pkg;

   // fixed field widths of the request and response transfers and of grid_size
   localparam int COORD_FIELD_BITS = 10;
   localparam int OWNER_BITS       = 16;
   localparam int GRID_SIZE_BITS   = 11;

   localparam logic [GRID_SIZE_BITS-1:0] GRID_SIZE_RESET = 11'd256;

   // one candidate slot
   typedef struct packed {
      logic                        slot_valid;
      logic [COORD_FIELD_BITS-1:0] seed_x;
      logic [COORD_FIELD_BITS-1:0] seed_y;
      logic [OWNER_BITS-1:0]       seed_owner;
      logic                        last_slot;
   } nsos_req_type;

   // one result per grid point
   typedef struct packed {
      logic [OWNER_BITS-1:0]       owner;
      logic                        is_default;
      logic [COORD_FIELD_BITS-1:0] point_x;
      logic [COORD_FIELD_BITS-1:0] point_y;
   } nsos_rsp_type;

endpackage

`default_nettype wire

FILE: src/nearest_seed_owner_select.sv
// Top level of the nearest seed owner selector.
// Depends on nsos_pkg and nsos_raster.
`timescale 1ns / 1ps
`default_nettype none

// Takes one candidate slot per clock and picks, for each grid point in raster
// order, the owner of the valid seed at the smallest squared Euclidean
// distance (earlier slot wins a tie). A slot marked last closes the point and
// yields one response; a point with no valid seed reports is_default with
// owner 0. Throughput is one slot per cycle. The first stage forms the two
// squared coordinate differences, the second adds them, compares against the
// running minimum and loads the response register. While a response waits
// under rsp_stall, slots that do not close a point keep flowing; a second
// closing slot is held in the first stage with req_stall high. The user must
// see that grid_size is written through csr_write / csr_wdata only while the
// block is idle; the block does not enforce it. grid_size resets to 256; the
// point counters also wrap at 2^COORD_BITS.

module nearest_seed_owner_select
   import nsos_pkg::*;
#(
   parameter int COORD_BITS = 10
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire nsos_req_type              req_payload,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output nsos_rsp_type                   rsp_payload,
   input  wire logic                      csr_write,
   input  wire logic [GRID_SIZE_BITS-1:0] csr_wdata
);

   localparam int SQ_BITS   = 2 * COORD_BITS;
   localparam int DIST_BITS = SQ_BITS + 1;

   // grid size register
   logic [GRID_SIZE_BITS-1:0] grid_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_size_ff <= GRID_SIZE_RESET;
      end else if (csr_write) begin
         grid_size_ff <= csr_wdata;
      end
   end

   // handshake control
   logic req_accept;
   logic s1_vld_ff, s1_vld_in;
   logic s1_move;
   logic s1_slot_valid_ff;
   logic s1_last_ff;
   logic rsp_valid_ff, rsp_valid_in;

   assign s1_move    = s1_vld_ff && (!s1_last_ff || !rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_vld_ff && !s1_move;
   assign req_accept = req_valid && !req_stall;

   // current grid point
   logic [COORD_BITS-1:0] column, row;

   nsos_raster #(
      .COORD_BITS(COORD_BITS)
   ) u_raster (
      .clock    (clock),
      .reset    (reset),
      .advance  (req_accept && req_payload.last_slot),
      .grid_size(grid_size_ff),
      .column   (column),
      .row      (row)
   );

   // stage 1: absolute differences and squares
   logic [COORD_BITS-1:0] seed_x, seed_y, dx, dy;
   logic [SQ_BITS-1:0]    dx_sq_in, dy_sq_in;

   always_comb begin
      seed_x   = COORD_BITS'(req_payload.seed_x);
      seed_y   = COORD_BITS'(req_payload.seed_y);
      dx       = (column >= seed_x) ? column - seed_x : seed_x - column;
      dy       = (row >= seed_y) ? row - seed_y : seed_y - row;
      dx_sq_in = SQ_BITS'(dx) * SQ_BITS'(dx);
      dy_sq_in = SQ_BITS'(dy) * SQ_BITS'(dy);
   end

   logic [SQ_BITS-1:0]    s1_dx_sq_ff, s1_dy_sq_ff;
   logic [OWNER_BITS-1:0] s1_owner_ff;
   logic [COORD_BITS-1:0] s1_px_ff, s1_py_ff;

   always_comb begin
      if (req_accept) begin
         s1_vld_in = 1'b1;
      end else if (s1_move) begin
         s1_vld_in = 1'b0;
      end else begin
         s1_vld_in = s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_slot_valid_ff <= req_payload.slot_valid;
         s1_last_ff       <= req_payload.last_slot;
         s1_owner_ff      <= req_payload.seed_owner;
         s1_dx_sq_ff      <= dx_sq_in;
         s1_dy_sq_ff      <= dy_sq_in;
         s1_px_ff         <= column;
         s1_py_ff         <= row;
      end
   end

   // stage 2: distance, running minimum and response
   logic [DIST_BITS-1:0]  seed_dist;
   logic                  take_new;
   logic                  cur_have;
   logic [OWNER_BITS-1:0] cur_owner;

   logic [DIST_BITS-1:0]  best_distance_ff, best_distance_in;
   logic [OWNER_BITS-1:0] best_owner_ff, best_owner_in;
   logic                  have_best_ff, have_best_in;
   nsos_rsp_type          rsp_payload_ff, rsp_payload_in;

   always_comb begin
      seed_dist = DIST_BITS'(s1_dx_sq_ff) + DIST_BITS'(s1_dy_sq_ff);
      take_new  = s1_slot_valid_ff && (!have_best_ff || seed_dist < best_distance_ff);
      cur_have  = have_best_ff || s1_slot_valid_ff;
      cur_owner = take_new ? s1_owner_ff : best_owner_ff;
   end

   always_comb begin
      best_distance_in = best_distance_ff;
      best_owner_in    = best_owner_ff;
      have_best_in     = have_best_ff;
      if (s1_move) begin
         if (s1_last_ff) begin
            best_distance_in = '0;
            best_owner_in    = '0;
            have_best_in     = 1'b0;
         end else if (take_new) begin
            best_distance_in = seed_dist;
            best_owner_in    = s1_owner_ff;
            have_best_in     = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_distance_ff <= '0;
         best_owner_ff    <= '0;
         have_best_ff     <= 1'b0;
      end else begin
         best_distance_ff <= best_distance_in;
         best_owner_ff    <= best_owner_in;
         have_best_ff     <= have_best_in;
      end
   end

   // response register
   always_comb begin
      rsp_payload_in.owner      = cur_have ? cur_owner : '0;
      rsp_payload_in.is_default = !cur_have;
      rsp_payload_in.point_x    = COORD_FIELD_BITS'(s1_px_ff);
      rsp_payload_in.point_y    = COORD_FIELD_BITS'(s1_py_ff);
   end

   always_comb begin
      if (s1_move && s1_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move && s1_last_ff) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

`ifndef SYNTHESIS
   // a default response never carries an owner
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.is_default |-> rsp_payload.owner == '0)
      else $error("default response with nonzero owner");

   // input back-pressure only from a blocked closing slot
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_vld_ff && s1_last_ff && rsp_valid_ff && rsp_stall)
      else $error("req_stall without a blocked closing slot");

   // closing a point clears the running minimum
   assert property (@(posedge clock) disable iff (reset)
      s1_move && s1_last_ff |=> !have_best_ff)
      else $error("running minimum not cleared after closing slot");

   // closing a point presents a response on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      s1_move && s1_last_ff |=> rsp_valid)
      else $error("closing slot did not produce a response");
`endif

endmodule

`default_nettype wire

FILE: src/nsos_raster.sv
// Raster point counter: column first, then row, wrapping at the grid size
// or at the coordinate range. Depends on nsos_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nsos_raster
   import nsos_pkg::*;
#(
   parameter int COORD_BITS = 10
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      advance,
   input  wire logic [GRID_SIZE_BITS-1:0] grid_size,
   output logic      [COORD_BITS-1:0]     column,
   output logic      [COORD_BITS-1:0]     row
);

   localparam int CMP_BITS = (COORD_BITS + 1 > GRID_SIZE_BITS) ? COORD_BITS + 1
                                                                 : GRID_SIZE_BITS;

   logic [COORD_BITS-1:0] column_ff, column_in;
   logic [COORD_BITS-1:0] row_ff, row_in;
   logic [COORD_BITS:0]   column_inc, row_inc;
   logic                  column_wrap, row_wrap;

   // increment and wrap test, greater-or-equal so a lowered size still wraps
   always_comb begin
      column_inc  = {1'b0, column_ff} + 1'b1;
      row_inc     = {1'b0, row_ff} + 1'b1;
      column_wrap = column_inc[COORD_BITS] ||
                    (CMP_BITS'(column_inc) >= CMP_BITS'(grid_size));
      row_wrap    = row_inc[COORD_BITS] ||
                    (CMP_BITS'(row_inc) >= CMP_BITS'(grid_size));
   end

   // next point
   always_comb begin
      column_in = column_ff;
      row_in    = row_ff;
      if (advance) begin
         if (column_wrap) begin
            column_in = '0;
            row_in    = row_wrap ? '0 : row_inc[COORD_BITS-1:0];
         end else begin
            column_in = column_inc[COORD_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         row_ff    <= '0;
      end else begin
         column_ff <= column_in;
         row_ff    <= row_in;
      end
   end

   assign column = column_ff;
   assign row    = row_ff;

endmodule

`default_nettype wire

FILE: tb/nearest_seed_owner_select_test.sv
// Self-checking testbench for nearest_seed_owner_select.
// Depends on nsos_pkg and the selector RTL; drives slots, predicts each owner
// result and compares it with the response transfers in order.
`timescale 1ns / 1ps

module nearest_seed_owner_select_test;
   import nsos_pkg::*;

   localparam int COORD_BITS   = 10;
   localparam int COORD_LIMIT  = 1 << COORD_BITS;
   localparam int COORD_MAX    = COORD_LIMIT - 1;
   localparam int SETTLE_TICKS = 6;
   localparam int HOLD_TICKS   = 120;
   localparam int REPORT_LIMIT = 10;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   nsos_req_type              req_payload;
   logic                      rsp_valid;
   logic                      rsp_stall;
   nsos_rsp_type              rsp_payload;
   logic                      csr_write;
   logic [GRID_SIZE_BITS-1:0] csr_wdata;

   // predicted scan state
   logic [GRID_SIZE_BITS-1:0]   grid_size_now;
   logic [COORD_FIELD_BITS-1:0] scan_col;
   logic [COORD_FIELD_BITS-1:0] scan_row;
   logic [2*COORD_BITS:0]       best_dist;
   logic [OWNER_BITS-1:0]       best_owner;
   bit                          have_best;

   nsos_rsp_type owner_results_due[$];

   int  slots_sent;
   int  owners_checked;
   int  defaults_checked;
   int  grid_writes;
   int  mismatch_count;
   bit  req_gaps_on;
   bit  rsp_stall_on;
   bit  hold_start;
   int  last_seed_x;
   int  last_seed_y;

   nearest_seed_owner_select #(
      .COORD_BITS (COORD_BITS)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_write   (csr_write),
      .csr_wdata   (csr_wdata)
   );

   // clock generation
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // run limit
   initial begin
      #(64'd20_000_000);
      $display("Verification failed");
      $finish;
   end

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic int clip_coord(input int v);
      if (v < 0) return 0;
      if (v > COORD_MAX) return COORD_MAX;
      return v;
   endfunction

   function automatic nsos_req_type make_slot(input bit valid, input int x, input int y,
                                              input int owner, input bit last);
      nsos_req_type s;
      s.slot_valid = valid;
      s.seed_x     = x[COORD_FIELD_BITS-1:0];
      s.seed_y     = y[COORD_FIELD_BITS-1:0];
      s.seed_owner = owner[OWNER_BITS-1:0];
      s.last_slot  = last;
      return s;
   endfunction

   // next counter value, wrapping at the grid size or the coordinate range
   function automatic logic [COORD_FIELD_BITS-1:0] advance_count(
         input logic [COORD_FIELD_BITS-1:0] cur, input logic [GRID_SIZE_BITS-1:0] size,
         output bit wrapped);
      int unsigned n;
      n = int'(cur) + 1;
      if (n >= int'(size) || n >= COORD_LIMIT) begin
         wrapped = 1'b1;
         return '0;
      end
      wrapped = 1'b0;
      return n[COORD_FIELD_BITS-1:0];
   endfunction

   // nearest seed tracking for one accepted slot
   task automatic track_slot(input nsos_req_type s);
      int            dx;
      int            dy;
      int unsigned   sq_dist;
      nsos_rsp_type  due;
      bit            wrapped;
      if (s.slot_valid) begin
         dx      = (s.seed_x >= scan_col) ? int'(s.seed_x) - int'(scan_col)
                                          : int'(scan_col) - int'(s.seed_x);
         dy      = (s.seed_y >= scan_row) ? int'(s.seed_y) - int'(scan_row)
                                          : int'(scan_row) - int'(s.seed_y);
         sq_dist = dx * dx + dy * dy;
         if (!have_best || sq_dist < best_dist) begin
            best_dist  = sq_dist[2*COORD_BITS:0];
            best_owner = s.seed_owner;
            have_best  = 1'b1;
         end
      end
      if (s.last_slot) begin
         due.owner      = have_best ? best_owner : '0;
         due.is_default = !have_best;
         due.point_x    = scan_col;
         due.point_y    = scan_row;
         owner_results_due = {owner_results_due, due};
         best_dist  = '0;
         best_owner = '0;
         have_best  = 1'b0;
         scan_col   = advance_count(scan_col, grid_size_now, wrapped);
         if (wrapped) scan_row = advance_count(scan_row, grid_size_now, wrapped);
      end
   endtask

   // one request transfer, then an optional idle gap
   task automatic send_slot(input nsos_req_type s);
      int gap;
      @(negedge clock);
      req_valid   <= 1'b1;
      req_payload <= s;
      do @(posedge clock); while (req_stall);
      track_slot(s);
      slots_sent++;
      gap = req_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // drop valid and wait until the block has gone quiet
   task automatic settle_block();
      @(negedge clock);
      req_valid <= 1'b0;
      while (owner_results_due.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic write_grid_size(input int size);
      settle_block();
      @(negedge clock);
      csr_write <= 1'b1;
      csr_wdata <= size[GRID_SIZE_BITS-1:0];
      @(negedge clock);
      csr_write <= 1'b0;
      grid_size_now = size[GRID_SIZE_BITS-1:0];
      grid_writes++;
   endtask

   // one random slot, often aimed near the current point
   function automatic nsos_req_type random_slot(input bit last);
      int r;
      int x;
      int y;
      int owner;
      r = $urandom_range(0, 99);
      if (r < 45) begin
         x = clip_coord(int'(scan_col) + int'($urandom_range(0, 16)) - 8);
         y = clip_coord(int'(scan_row) + int'($urandom_range(0, 16)) - 8);
      end else if (r < 75) begin
         x = $urandom_range(0, COORD_MAX);
         y = $urandom_range(0, COORD_MAX);
      end else begin
         // same spot as the previous seed, so the distances tie
         x = last_seed_x;
         y = last_seed_y;
      end
      last_seed_x = x;
      last_seed_y = y;
      r = $urandom_range(0, 19);
      owner = (r == 0) ? 0 : (r == 1) ? 16'hFFFF : $urandom_range(0, 16'hFFFF);
      return make_slot($urandom_range(0, 99) < 85, x, y, owner, last);
   endfunction

   // one grid point as a run of slots, or now and then a stray noise slot
   task automatic send_random_point();
      int           n;
      nsos_req_type s;
      if ($urandom_range(0, 9) == 0) begin
         s.slot_valid = 1'($urandom);
         s.seed_x     = COORD_FIELD_BITS'($urandom);
         s.seed_y     = COORD_FIELD_BITS'($urandom);
         s.seed_owner = OWNER_BITS'($urandom_range(0, 16'hFFFF));
         s.last_slot  = 1'($urandom);
         send_slot(s);
      end else begin
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
         for (int i = 0; i < n; i++) send_slot(random_slot(i == n - 1));
      end
   endtask

   // response side: random stalls and one long hold-off on request
   initial begin
      int n;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_start) begin
            hold_start = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_TICKS - 1) @(negedge clock);
         end else if (!rsp_stall_on) begin
            rsp_stall <= 1'b0;
         end else begin
            n = pick_gap();
            if (n == 0) begin
               rsp_stall <= 1'b0;
            end else begin
               rsp_stall <= 1'b1;
               repeat (n - 1) @(negedge clock);
            end
         end
      end
   end

   // compare each response transfer with the oldest prediction
   always @(posedge clock) begin
      nsos_rsp_type due;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (owner_results_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("unexpected result: owner %h default %b point (%0d,%0d)",
                        rsp_payload.owner, rsp_payload.is_default,
                        rsp_payload.point_x, rsp_payload.point_y);
         end else begin
            due = owner_results_due.pop_front();
            if (rsp_payload.owner !== due.owner ||
                rsp_payload.is_default !== due.is_default ||
                rsp_payload.point_x !== due.point_x ||
                rsp_payload.point_y !== due.point_y) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("mismatch: expected owner %h default %b point (%0d,%0d)",
                           due.owner, due.is_default, due.point_x, due.point_y);
                  $display("          got      owner %h default %b point (%0d,%0d)",
                           rsp_payload.owner, rsp_payload.is_default,
                           rsp_payload.point_x, rsp_payload.point_y);
               end
            end
            owners_checked++;
            if (due.is_default) defaults_checked++;
         end
      end
   end

   // an empty point and a single seed at reset grid size
   task automatic test_reset_defaults();
      send_slot(make_slot(1'b0, COORD_MAX, 17, 16'hA5A5, 1'b1));
      send_slot(make_slot(1'b1, 300, 2, 16'h1234, 1'b1));
   endtask

   // coordinate and owner extremes
   task automatic test_field_extremes();
      send_slot(make_slot(1'b1, COORD_MAX, COORD_MAX, 16'hFFFF, 1'b0));
      send_slot(make_slot(1'b1, 0, 0, 16'h0000, 1'b0));
      send_slot(make_slot(1'b0, COORD_MAX, COORD_MAX, 16'hFFFF, 1'b1));
      send_slot(make_slot(1'b1, COORD_MAX, 0, 16'hFFFF, 1'b1));
   endtask

   // equal distance keeps the earlier slot, a closer later slot replaces it
   task automatic test_tie_order();
      send_slot(make_slot(1'b1, int'(scan_col) + 2, 0, 16'h0AAA, 1'b0));
      send_slot(make_slot(1'b1, int'(scan_col) - 2, 0, 16'h0BBB, 1'b1));
      send_slot(make_slot(1'b1, scan_col, 3, 16'h0CCC, 1'b0));
      send_slot(make_slot(1'b1, scan_col, 1, 16'h0DDD, 1'b1));
   endtask

   // slots without the last mark give no result until an invalid one closes
   task automatic test_open_point();
      send_slot(make_slot(1'b1, 40, 40, 16'h4040, 1'b0));
      send_slot(make_slot(1'b1, 9, 0, 16'h0909, 1'b0));
      send_slot(make_slot(1'b0, 9, 0, 16'hDEAD, 1'b1));
   endtask

   // grid sizes of one and zero pin the point at the origin
   task automatic test_tiny_grid();
      write_grid_size(1);
      for (int i = 0; i < 3; i++) send_slot(make_slot(i[0], i, i, 16'h0100 + i, 1'b1));
      write_grid_size(0);
      for (int i = 0; i < 2; i++) send_slot(make_slot(1'b1, 5, 5, 16'h0200 + i, 1'b1));
   endtask

   // grid lowered below the current column wraps on the next advance
   task automatic test_grid_lowered();
      write_grid_size(1024);
      for (int i = 0; i < 5; i++) send_slot(make_slot(1'b0, 0, 0, 0, 1'b1));
      write_grid_size(3);
      for (int i = 0; i < 2; i++) send_slot(make_slot(1'b1, 7, 1, 16'h0300 + i, 1'b1));
   endtask

   // grid wider than the coordinate range: counters wrap at the range
   task automatic test_coordinate_wrap();
      write_grid_size(2047);
      req_gaps_on  = 1'b0;
      rsp_stall_on = 1'b0;
      for (int i = 0; i < COORD_LIMIT + 6; i++) send_slot(random_slot(1'b1));
      write_grid_size(1024);
      for (int i = 0; i < 3; i++) send_slot(random_slot(1'b1));
   endtask

   // long receiver hold-off while slots keep coming
   task automatic test_backpressure();
      write_grid_size(4);
      req_gaps_on  = 1'b0;
      rsp_stall_on = 1'b0;
      @(negedge clock);
      hold_start = 1'b1;
      for (int i = 0; i < 60; i++) send_slot(random_slot($urandom_range(0, 99) < 60));
      send_slot(random_slot(1'b1));
   endtask

   // random traffic over a spread of grid sizes and idling patterns
   task automatic test_random_traffic();
      int grid_choices[10] = '{0, 1, 2, 3, 5, 17, 256, 1024, 2047, 9};
      int phase_start;
      for (int p = 0; p < 10; p++) begin
         write_grid_size(grid_choices[p]);
         req_gaps_on  = (p % 3) != 0;
         rsp_stall_on = (p % 4) != 1;
         phase_start  = slots_sent;
         while (slots_sent - phase_start < 8) send_random_point();
      end
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_payload   = '0;
      csr_write     = 1'b0;
      csr_wdata     = GRID_SIZE_RESET;
      grid_size_now = GRID_SIZE_RESET;
      scan_col      = '0;
      scan_row      = '0;
      best_dist     = '0;
      best_owner    = '0;
      have_best     = 1'b0;
      req_gaps_on   = 1'b1;
      rsp_stall_on  = 1'b1;
      hold_start    = 1'b0;
      last_seed_x   = 0;
      last_seed_y   = 0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_field_extremes();
      test_tie_order();
      test_open_point();
      test_tiny_grid();
      test_grid_lowered();
      test_coordinate_wrap();
      test_backpressure();
      test_random_traffic();
      settle_block();

      if (owner_results_due.size() != 0) begin
         mismatch_count++;
         $display("%0d predicted results never arrived", owner_results_due.size());
      end
      $display("covered %0d slots and %0d point results (%0d default)",
               slots_sent, owners_checked, defaults_checked);
      $display("over %0d grid size writes, mismatches counted: %0d",
               grid_writes, mismatch_count);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
